### src/dspu_pkg.sv
// ----------------------------------------------------------------------------
// dspu_pkg
// shared types and constants of the subpicture run-length decoder
// ----------------------------------------------------------------------------
`default_nettype none

package dspu_pkg;

    // register reset values and limits
    localparam int AREA_WIDTH_RESET  = 720;
    localparam int AREA_HEIGHT_RESET = 576;
    localparam int MAX_WIDTH_DEFAULT = 4096;
    localparam int HEIGHT_LIMIT      = 4096;

    // register indexes (byte address is 4 * index)
    localparam logic REG_AREA_WIDTH  = 1'b0;
    localparam logic REG_AREA_HEIGHT = 1'b1;

    // depth of the token queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_DATA         = 2'd0,
        KIND_START_TOP    = 2'd1,
        KIND_START_BOTTOM = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
    } t_token;

    typedef struct packed {
        logic [12:0] area_width;
        logic [12:0] area_height;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  run_color;
        logic [12:0] run_length;
        logic [11:0] row;
        logic [11:0] column;
        logic        line_end;
        logic        field_done;
        logic        last;
    } t_run;

endpackage

`default_nettype wire

### src/dspu_if.sv
// ----------------------------------------------------------------------------
// dspu_if
// valid/ready channels for input bytes and decoded runs
// ----------------------------------------------------------------------------
`default_nettype none

interface dspu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       field_start;
    logic       bottom_field;

    modport source (output valid, output data_byte, output field_start,
                    output bottom_field, input ready);
    modport sink   (input valid, input data_byte, input field_start,
                    input bottom_field, output ready);
endinterface

interface dspu_run_if;
    logic        valid;
    logic        ready;
    logic [1:0]  run_color;
    logic [12:0] run_length;
    logic [11:0] row;
    logic [11:0] column;
    logic        line_end;
    logic        field_done;
    logic        last;

    modport source (output valid, output run_color, output run_length, output row,
                    output column, output line_end, output field_done, output last,
                    input ready);
    modport sink   (input valid, input run_color, input run_length, input row,
                    input column, input line_end, input field_done, input last,
                    output ready);
endinterface

`default_nettype wire

### src/dspu_front.sv
// ----------------------------------------------------------------------------
// dspu_front
// byte intake: tags each byte by field start kind and queues it
// ----------------------------------------------------------------------------
`default_nettype none

module dspu_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    dspu_byte_if.sink       i_byte,
    input  wire             i_pop,
    output logic            o_head_valid,
    output dspu_pkg::t_token o_head
);

    localparam int PtrW = (dspu_pkg::QUEUE_DEPTH > 1) ? $clog2(dspu_pkg::QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(dspu_pkg::QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(dspu_pkg::QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(dspu_pkg::QUEUE_DEPTH);

    dspu_pkg::t_token r_mem [dspu_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]  r_wr;
    logic [PtrW-1:0]  r_rd;
    logic [CntW-1:0]  r_count;

    dspu_pkg::t_token n_token;
    logic             push;
    logic             pop;

    always_comb begin
        n_token.data_byte = i_byte.data_byte;
        if (!i_byte.field_start) begin
            n_token.kind = dspu_pkg::KIND_DATA;
        end else if (i_byte.bottom_field) begin
            n_token.kind = dspu_pkg::KIND_START_BOTTOM;
        end else begin
            n_token.kind = dspu_pkg::KIND_START_TOP;
        end
    end

    assign i_byte.ready = (r_count != FullCnt);
    assign push         = i_byte.valid && i_byte.ready;
    assign pop          = i_pop && o_head_valid;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= n_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/dspu_back.sv
// ----------------------------------------------------------------------------
// dspu_back
// nibble sequencer: gathers codes, places runs on lines, drives the run output
// ----------------------------------------------------------------------------
`default_nettype none

module dspu_back #(
    parameter int MAX_WIDTH = dspu_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  dspu_pkg::t_cfg   i_cfg,
    input  wire              i_head_valid,
    input  dspu_pkg::t_token i_head,
    output logic             o_pop,
    dspu_run_if.source       o_run
);

    localparam logic [12:0] MaxW   = 13'(MAX_WIDTH);
    localparam logic [12:0] HLimit = 13'(dspu_pkg::HEIGHT_LIMIT);

    typedef enum logic {
        PH_HIGH,
        PH_LOW
    } t_phase;

    function automatic logic [12:0] field_lines(input logic [12:0] height,
                                                input logic bottom);
        logic [12:0] h;
        logic [12:0] h1;
        h  = (height > HLimit) ? HLimit : height;
        h1 = h + 13'd1;
        return bottom ? {1'b0, h[12:1]} : {1'b0, h1[12:1]};
    endfunction

    t_phase         r_phase;
    logic [11:0]    r_acc;
    logic [1:0]     r_ng;
    logic [12:0]    r_col;
    logic [11:0]    r_line;
    logic           r_field;
    logic           r_complete;
    dspu_pkg::t_run r_out;
    logic           r_out_valid;

    logic [11:0]    n_acc;
    logic [1:0]     n_ng;
    logic [12:0]    n_col;
    logic [11:0]    n_line;
    logic           n_field;
    logic           n_complete;
    dspu_pkg::t_run n_run;

    logic           is_start;
    logic [11:0]    e_acc;
    logic [1:0]     e_ng;
    logic [12:0]    e_col;
    logic [11:0]    e_line;
    logic           e_field;
    logic           e_complete;
    logic [12:0]    e_lines;
    logic [3:0]     nib;
    logic [15:0]    value;
    logic           done;
    logic [12:0]    w_eff;
    logic [12:0]    col_eff;
    logic [12:0]    rem;
    logic [13:0]    len_raw;
    logic [12:0]    len;
    logic           line_done;
    logic [12:0]    next_line;
    logic           fdone;
    logic           run_now;
    logic           can_emit;
    logic           step;

    // a field start applies before the high nibble of its byte
    assign is_start   = (r_phase == PH_HIGH) && (i_head.kind != dspu_pkg::KIND_DATA);
    assign e_field    = is_start ? (i_head.kind == dspu_pkg::KIND_START_BOTTOM) : r_field;
    assign e_lines    = field_lines(i_cfg.area_height, e_field);
    assign e_acc      = is_start ? '0 : r_acc;
    assign e_ng       = is_start ? '0 : r_ng;
    assign e_col      = is_start ? '0 : r_col;
    assign e_line     = is_start ? '0 : r_line;
    assign e_complete = is_start ? (e_lines == '0) : r_complete;

    assign nib   = (r_phase == PH_HIGH) ? i_head.data_byte[7:4] : i_head.data_byte[3:0];
    assign value = {e_acc, nib};

    always_comb begin
        unique case (e_ng)
            2'd0:    done = (value >= 16'h0004);
            2'd1:    done = (value >= 16'h0010);
            2'd2:    done = (value >= 16'h0040);
            default: done = 1'b1;
        endcase
    end

    assign w_eff     = (i_cfg.area_width == '0) ? 13'd1 :
                       ((i_cfg.area_width > MaxW) ? MaxW : i_cfg.area_width);
    assign col_eff   = (e_col >= w_eff) ? '0 : e_col;
    assign rem       = w_eff - col_eff;
    assign len_raw   = value[15:2];
    assign len       = ((len_raw == '0) || (len_raw > {1'b0, rem})) ? rem : len_raw[12:0];
    // len never exceeds rem, so the line ends exactly when it takes all of it
    assign line_done = (len == rem);
    assign next_line = {1'b0, e_line} + 13'd1;
    assign fdone     = line_done && (next_line >= e_lines);

    assign run_now  = !e_complete && done;
    assign can_emit = !r_out_valid || o_run.ready;
    assign step     = i_head_valid && (!run_now || can_emit);
    assign o_pop    = step && ((r_phase == PH_LOW) || e_complete || (run_now && line_done));

    always_comb begin
        n_acc      = e_acc;
        n_ng       = e_ng;
        n_col      = e_col;
        n_line     = e_line;
        n_field    = e_field;
        n_complete = e_complete;
        if (!e_complete) begin
            if (done) begin
                n_acc = '0;
                n_ng  = '0;
                if (line_done) begin
                    n_col  = '0;
                    n_line = next_line[11:0];
                    if (fdone) begin
                        n_complete = 1'b1;
                    end
                end else begin
                    n_col = col_eff + len;
                end
            end else begin
                n_acc = value[11:0];
                n_ng  = e_ng + 2'd1;
            end
        end

        n_run.run_color  = value[1:0];
        n_run.run_length = len;
        n_run.row        = {e_line[10:0], e_field};
        n_run.column     = col_eff[11:0];
        n_run.line_end   = line_done;
        n_run.field_done = fdone;
        // after a plain high-nibble run the low nibble gives a run only if it is 4 or more
        n_run.last       = (r_phase == PH_LOW) || line_done ||
                           (i_head.data_byte[3:0] < 4'd4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HIGH;
            r_acc       <= '0;
            r_ng        <= '0;
            r_col       <= '0;
            r_line      <= '0;
            r_field     <= 1'b0;
            r_complete  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_run.ready) begin
                r_out_valid <= 1'b0;
            end
            if (step) begin
                r_phase    <= o_pop ? PH_HIGH : PH_LOW;
                r_acc      <= n_acc;
                r_ng       <= n_ng;
                r_col      <= n_col;
                r_line     <= n_line;
                r_field    <= n_field;
                r_complete <= n_complete;
                if (run_now) begin
                    r_out       <= n_run;
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    assign o_run.valid      = r_out_valid;
    assign o_run.run_color  = r_out.run_color;
    assign o_run.run_length = r_out.run_length;
    assign o_run.row        = r_out.row;
    assign o_run.column     = r_out.column;
    assign o_run.line_end   = r_out.line_end;
    assign o_run.field_done = r_out.field_done;
    assign o_run.last       = r_out.last;

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.run_length != '0))
        else $error("run of zero length");

    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.line_end) |-> r_out.last)
        else $error("line end run not last of its byte");

    a_done_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.field_done) |-> r_out.line_end)
        else $error("field done without line end");

    a_low_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LOW) |-> i_head_valid)
        else $error("low nibble phase without a queued byte");

    a_done_sets_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_out.field_done) |-> r_complete)
        else $error("field done run left the field open");

endmodule

`default_nettype wire

### src/dvd_subpicture_rle_decoder_core.sv
// ----------------------------------------------------------------------------
// dvd_subpicture_rle_decoder_core
// run-length decoder for one field of dvd subpicture pixel data
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        transfer
//  i_byte    in   valid/ready      data byte, field start, bottom field
//  o_run     out  valid/ready      color, length, row, column, line/field flags
//  apb       in   psel/penable     area_width at 0x0, area_height at 0x4
//
//  each byte passes through the nibble sequencer one nibble at a time; its
//  high nibble alone suffices when it ends a line or the field is idle
//  both nibbles share one nibble decode; a finished code waits while the run register is full
//  reset is synchronous active low; registers return to 720 by 576
//  a two-entry token queue and a one-deep run register let each side stall
//  on its own; no clearing pass after reset
//
// ----------------------------------------------------------------------------
`default_nettype none

module dvd_subpicture_rle_decoder_core #(
    parameter int MAX_WIDTH = dspu_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dspu_byte_if.sink   i_byte,
    dspu_run_if.source  o_run,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    dspu_pkg::t_cfg r_cfg;
    logic           cfg_write;

    // front to back token path
    logic             head_valid;
    dspu_pkg::t_token head;
    logic             pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.area_width  <= 13'(dspu_pkg::AREA_WIDTH_RESET);
            r_cfg.area_height <= 13'(dspu_pkg::AREA_HEIGHT_RESET);
        end else if (cfg_write) begin
            unique case (paddr[2])
                dspu_pkg::REG_AREA_WIDTH:  r_cfg.area_width  <= pwdata[12:0];
                dspu_pkg::REG_AREA_HEIGHT: r_cfg.area_height <= pwdata[12:0];
                default:                   r_cfg             <= r_cfg;
            endcase
        end
    end

    // read back, register index from the word address
    always_comb begin
        unique case (paddr[2])
            dspu_pkg::REG_AREA_WIDTH:  prdata = {19'd0, r_cfg.area_width};
            dspu_pkg::REG_AREA_HEIGHT: prdata = {19'd0, r_cfg.area_height};
            default:                   prdata = '0;
        endcase
    end

    // intake and classification of bytes
    dspu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // code gathering, line placement and run output
    dspu_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_run        (o_run)
    );

endmodule

`default_nettype wire
